/* rtl/assert_macros.svh */
// Assertion macros used by the zone check top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define LRZC_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define LRZC_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/lrzc_pkg.sv */
// Types, constants and trig ROM builders for the lidar zone check.
`timescale 1ns / 1ps

package lrzc_pkg;

    localparam int SAMPLES_PER_TURN   = 2048;
    localparam int TRIG_FRACTION_BITS = 15;

    localparam int RANGE_W     = 16;
    localparam int POS_W       = 11;
    localparam int IDX_W       = $clog2(SAMPLES_PER_TURN);
    localparam int CNT_W       = IDX_W + 1;
    localparam int QUARTER     = SAMPLES_PER_TURN / 4;
    localparam int RIGHT_START = (3 * SAMPLES_PER_TURN) / 4;
    localparam int OFFSET_MAX  = SAMPLES_PER_TURN - RIGHT_START;
    localparam int OFF_W       = $clog2(OFFSET_MAX + 1);
    localparam int TRIG_W      = TRIG_FRACTION_BITS + 1;
    localparam int PROD_W      = RANGE_W + TRIG_W;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W     = FIFO_AW + 1;

    localparam logic [RANGE_W-1:0] FRONT_DISTANCE_RESET = 16'd2000;
    localparam logic [RANGE_W-1:0] HALF_WIDTH_RESET     = 16'd800;

    typedef enum logic [0:0] {
        REG_FRONT_DISTANCE = 1'b0,
        REG_HALF_WIDTH     = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               scan_last;
    } sample_t;

    typedef struct packed {
        logic               stop_request;
        logic [POS_W-1:0]   hit_position;
        logic [RANGE_W-1:0] hit_distance;
    } result_t;

    // Classified sample handed from the front end to the accumulator.
    typedef struct packed {
        logic               hit;
        logic               last;
        logic [IDX_W-1:0]   index;
        logic [RANGE_W-1:0] range_mm;
    } zone_item_t;

    typedef logic [TRIG_W-1:0] trig_rom_t [0:OFFSET_MAX];

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] K1      = 64'd1686629713;
    localparam logic [63:0] K3      = 64'd693598669;
    localparam logic [63:0] K5      = 64'd85569306;
    localparam logic [63:0] K7      = 64'd5026995;
    localparam logic [63:0] K9      = 64'd172273;

    // sin(pi/2 * x), x in Q30; elaboration only, used to fill the ROMs.
    function automatic logic [TRIG_W-1:0] quarter_sine(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] r;
        x  = (x_in > Q30_ONE) ? Q30_ONE : x_in;
        x2 = (x * x) >> 30;
        p  = K9;
        p  = K7 - ((x2 * p) >> 30);
        p  = K5 - ((x2 * p) >> 30);
        p  = K3 - ((x2 * p) >> 30);
        p  = K1 - ((x2 * p) >> 30);
        s  = (x * p) >> 30;
        r  = (s + (64'd1 << (29 - TRIG_FRACTION_BITS))) >> (30 - TRIG_FRACTION_BITS);
        if (r > (64'd1 << TRIG_FRACTION_BITS))
        begin
            r = 64'd1 << TRIG_FRACTION_BITS;
        end
        return r[TRIG_W-1:0];
    endfunction

    function automatic logic [63:0] offset_angle(input int k);
        logic [63:0] x;
        x = (64'(k) << 32) / SAMPLES_PER_TURN;
        return (x > Q30_ONE) ? Q30_ONE : x;
    endfunction

    function automatic trig_rom_t build_sin_rom();
        trig_rom_t rom;
        for (int k = 0; k <= OFFSET_MAX; k++)
        begin
            rom[k] = quarter_sine(offset_angle(k));
        end
        return rom;
    endfunction

    function automatic trig_rom_t build_cos_rom();
        trig_rom_t rom;
        for (int k = 0; k <= OFFSET_MAX; k++)
        begin
            rom[k] = quarter_sine(Q30_ONE - offset_angle(k));
        end
        return rom;
    endfunction

endpackage

/* rtl/lrzc_front.sv */
// Front end: sample counter, sector decode, trig lookup and rectangle test.
`timescale 1ns / 1ps

module lrzc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  lrzc_pkg::sample_t             sample,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [lrzc_pkg::RANGE_W-1:0]  cfg_data,
    input  logic [lrzc_pkg::LEVEL_W-1:0]  fifo_level,
    output logic                          push,
    output lrzc_pkg::zone_item_t          push_item
);

    localparam lrzc_pkg::trig_rom_t SIN_ROM = lrzc_pkg::build_sin_rom();
    localparam lrzc_pkg::trig_rom_t COS_ROM = lrzc_pkg::build_cos_rom();
    localparam int SUM_W = lrzc_pkg::LEVEL_W + 1;

    logic [lrzc_pkg::RANGE_W-1:0] front_distance_reg;
    logic [lrzc_pkg::RANGE_W-1:0] half_width_reg;
    logic [lrzc_pkg::IDX_W-1:0]   counter_reg;
    logic [lrzc_pkg::IDX_W-1:0]   counter_next;

    logic                         s1_valid_reg;
    logic                         s1_checked_reg;
    logic                         s1_last_reg;
    logic [lrzc_pkg::IDX_W-1:0]   s1_index_reg;
    logic [lrzc_pkg::RANGE_W-1:0] s1_range_reg;
    logic [lrzc_pkg::TRIG_W-1:0]  s1_sin_reg;
    logic [lrzc_pkg::TRIG_W-1:0]  s1_cos_reg;

    logic                         s2_valid_reg;
    logic                         s2_checked_reg;
    logic                         s2_last_reg;
    logic                         s2_zero_reg;
    logic [lrzc_pkg::IDX_W-1:0]   s2_index_reg;
    logic [lrzc_pkg::RANGE_W-1:0] s2_range_reg;
    logic [lrzc_pkg::PROD_W-1:0]  s2_prod_cos_reg;
    logic [lrzc_pkg::PROD_W-1:0]  s2_prod_sin_reg;

    logic                         accept;
    logic                         in_left;
    logic                         in_right;
    logic [lrzc_pkg::CNT_W-1:0]   right_offset;
    logic [lrzc_pkg::OFF_W-1:0]   offset;
    logic [SUM_W-1:0]             committed;
    logic [lrzc_pkg::PROD_W-1:0]  front_limit;
    logic [lrzc_pkg::PROD_W-1:0]  side_limit;

    // Credit check: queue entries plus beats still in the pipe.
    assign committed    = SUM_W'(fifo_level) + SUM_W'(s1_valid_reg) + SUM_W'(s2_valid_reg);
    assign sample_stall = (committed >= SUM_W'(lrzc_pkg::FIFO_DEPTH));
    assign accept       = sample_valid && !sample_stall;

    assign in_left      = (counter_reg < lrzc_pkg::IDX_W'(lrzc_pkg::QUARTER));
    assign in_right     = (counter_reg >= lrzc_pkg::IDX_W'(lrzc_pkg::RIGHT_START));
    assign right_offset = lrzc_pkg::CNT_W'(lrzc_pkg::SAMPLES_PER_TURN)
                          - lrzc_pkg::CNT_W'(counter_reg);
    assign offset       = in_left ? lrzc_pkg::OFF_W'(counter_reg)
                                  : (in_right ? lrzc_pkg::OFF_W'(right_offset) : '0);

    always_comb
    begin
        if (sample.scan_last ||
            counter_reg == lrzc_pkg::IDX_W'(lrzc_pkg::SAMPLES_PER_TURN - 1))
        begin
            counter_next = '0;
        end
        else
        begin
            counter_next = counter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_distance_reg <= lrzc_pkg::FRONT_DISTANCE_RESET;
            half_width_reg     <= lrzc_pkg::HALF_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lrzc_pkg::REG_FRONT_DISTANCE: front_distance_reg <= cfg_data;
                lrzc_pkg::REG_HALF_WIDTH:     half_width_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                counter_reg <= counter_next;
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 1: ROM read; stage 2: range times sin/cos.
    always_ff @(posedge clk)
    begin
        s1_checked_reg  <= in_left || in_right;
        s1_last_reg     <= sample.scan_last;
        s1_index_reg    <= counter_reg;
        s1_range_reg    <= sample.range_mm;
        s1_sin_reg      <= SIN_ROM[offset];
        s1_cos_reg      <= COS_ROM[offset];

        s2_checked_reg  <= s1_checked_reg;
        s2_last_reg     <= s1_last_reg;
        s2_zero_reg     <= (s1_range_reg == '0);
        s2_index_reg    <= s1_index_reg;
        s2_range_reg    <= s1_range_reg;
        s2_prod_cos_reg <= s1_range_reg * s1_cos_reg;
        s2_prod_sin_reg <= s1_range_reg * s1_sin_reg;
    end

    assign front_limit = lrzc_pkg::PROD_W'({front_distance_reg,
                                            {lrzc_pkg::TRIG_FRACTION_BITS{1'b0}}});
    assign side_limit  = lrzc_pkg::PROD_W'({half_width_reg,
                                            {lrzc_pkg::TRIG_FRACTION_BITS{1'b0}}});

    assign push               = s2_valid_reg;
    assign push_item.hit      = s2_checked_reg &&
                                (s2_zero_reg ||
                                 (s2_prod_cos_reg < front_limit &&
                                  s2_prod_sin_reg < side_limit));
    assign push_item.last     = s2_last_reg;
    assign push_item.index    = s2_index_reg;
    assign push_item.range_mm = s2_range_reg;

endmodule

/* rtl/lrzc_fifo.sv */
// Short queue of classified samples between front end and accumulator.
`timescale 1ns / 1ps

module lrzc_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  lrzc_pkg::zone_item_t          push_item,
    input  logic                          pop,
    output logic                          not_empty,
    output lrzc_pkg::zone_item_t          head,
    output logic [lrzc_pkg::LEVEL_W-1:0]  level
);

    lrzc_pkg::zone_item_t           entries [0:lrzc_pkg::FIFO_DEPTH-1];
    logic [lrzc_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [lrzc_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [lrzc_pkg::LEVEL_W-1:0]   level_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_reg + lrzc_pkg::LEVEL_W'(push) - lrzc_pkg::LEVEL_W'(pop);
        end
    end

    assign not_empty = (level_reg != '0);
    assign head      = entries[rd_ptr_reg];
    assign level     = level_reg;

endmodule

/* rtl/lrzc_back.sv */
// Accumulator: keeps the first hit of the turn and drives the result register.
`timescale 1ns / 1ps

module lrzc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  not_empty,
    input  lrzc_pkg::zone_item_t  head,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output lrzc_pkg::result_t     result
);

    logic                         hit_seen_reg;
    logic                         hit_seen_next;
    logic [lrzc_pkg::IDX_W-1:0]   hit_index_reg;
    logic [lrzc_pkg::IDX_W-1:0]   hit_index_next;
    logic [lrzc_pkg::RANGE_W-1:0] hit_range_reg;
    logic [lrzc_pkg::RANGE_W-1:0] hit_range_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    lrzc_pkg::result_t            out_reg;
    lrzc_pkg::result_t            out_next;

    logic                         take;
    logic                         seen_now;
    logic [lrzc_pkg::IDX_W-1:0]   index_now;
    logic [lrzc_pkg::RANGE_W-1:0] range_now;

    // A last-of-scan beat needs room in the result register.
    assign pop       = not_empty && (!head.last || !out_valid_reg || !result_stall);
    assign take      = head.hit && !hit_seen_reg;
    assign seen_now  = hit_seen_reg || head.hit;
    assign index_now = take ? head.index : hit_index_reg;
    assign range_now = take ? head.range_mm : hit_range_reg;

    always_comb
    begin
        hit_seen_next  = hit_seen_reg;
        hit_index_next = hit_index_reg;
        hit_range_next = hit_range_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        if (pop)
        begin
            if (head.last)
            begin
                out_valid_next        = 1'b1;
                out_next.stop_request = seen_now;
                out_next.hit_position = seen_now ? lrzc_pkg::POS_W'(index_now) : '0;
                out_next.hit_distance = seen_now ? range_now : '0;
                hit_seen_next         = 1'b0;
                hit_index_next        = '0;
                hit_range_next        = '0;
            end
            else
            begin
                hit_seen_next  = seen_now;
                hit_index_next = index_now;
                hit_range_next = range_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_seen_reg  <= 1'b0;
            hit_index_reg <= '0;
            hit_range_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hit_seen_reg  <= hit_seen_next;
            hit_index_reg <= hit_index_next;
            hit_range_reg <= hit_range_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* rtl/lidar_rectangle_zone_check.sv */
// Lidar rectangular front-zone check, one range sample per beat.
// Throughput: one sample per cycle while sample_stall is low; the
// 8-entry queue between the two-stage front end and the accumulator
// takes up result-side stalls; a result is registered as a last beat leaves it.
// Reset: async active low; clears counters, queue and kept hit, loads
// front distance 2000 mm and half width 800 mm.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lidar_rectangle_zone_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  lrzc_pkg::sample_t             sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output lrzc_pkg::result_t             result,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [lrzc_pkg::RANGE_W-1:0]  cfg_data
);

    logic                          push;
    lrzc_pkg::zone_item_t          push_item;
    logic                          pop;
    logic                          not_empty;
    lrzc_pkg::zone_item_t          head;
    logic [lrzc_pkg::LEVEL_W-1:0]  fifo_level;

    lrzc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fifo_level   (fifo_level),
        .push         (push),
        .push_item    (push_item)
    );

    lrzc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head),
        .level     (fifo_level)
    );

    lrzc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `LRZC_ASSERT_ALWAYS(a_level_bound, clk, rst_n,
        fifo_level <= lrzc_pkg::LEVEL_W'(lrzc_pkg::FIFO_DEPTH))
    `LRZC_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push,
        fifo_level < lrzc_pkg::LEVEL_W'(lrzc_pkg::FIFO_DEPTH) || pop)
    `LRZC_ASSERT_IMPLIES(a_empty_takes, clk, rst_n, fifo_level == '0, !sample_stall)
    `LRZC_ASSERT_IMPLIES(a_no_hit_zero, clk, rst_n,
        result_valid && !result.stop_request,
        result.hit_position == '0 && result.hit_distance == '0)

endmodule

/* test/lidar_rectangle_zone_check_test.sv */
// Self-checking testbench for the lidar rectangular front-zone check.
`timescale 1ns / 1ps

module lidar_rectangle_zone_check_test;

    localparam logic [63:0] Q30_UNIT  = 64'd1073741824;
    localparam logic [63:0] TAYLOR_C1 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_C3 = 64'd693598669;
    localparam logic [63:0] TAYLOR_C5 = 64'd85569306;
    localparam logic [63:0] TAYLOR_C7 = 64'd5026995;
    localparam logic [63:0] TAYLOR_C9 = 64'd172273;

    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    logic                          clk;
    logic                          rst_n;
    logic                          sample_valid;
    logic                          sample_stall;
    lrzc_pkg::sample_t             sample;
    logic                          result_valid;
    logic                          result_stall;
    lrzc_pkg::result_t             result;
    logic                          cfg_we;
    logic [0:0]                    cfg_index;
    logic [lrzc_pkg::RANGE_W-1:0]  cfg_data;

    // Model of the zone check
    logic [15:0]                   sin_q15 [0:lrzc_pkg::OFFSET_MAX];
    logic [15:0]                   cos_q15 [0:lrzc_pkg::OFFSET_MAX];
    logic [lrzc_pkg::RANGE_W-1:0]  front_mm;
    logic [lrzc_pkg::RANGE_W-1:0]  half_mm;
    int                            turn_index;
    bit                            hit_kept;
    int                            kept_index;
    logic [lrzc_pkg::RANGE_W-1:0]  kept_range;
    lrzc_pkg::result_t             pending_results [$];

    lrzc_pkg::result_t             oldest_result;
    int                            mismatch_count;
    int                            quiet_cycles;
    bit                            idle_enable;

    lidar_rectangle_zone_check dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // sin(pi/2 * x) for x in Q30, rounded to the trig fraction width
    function automatic logic [15:0] quarter_turn_sine(input logic [63:0] phase);
        logic [63:0] x;
        logic [63:0] x_sq;
        logic [63:0] poly;
        logic [63:0] prod;
        logic [63:0] rounded;
        x    = (phase > Q30_UNIT) ? Q30_UNIT : phase;
        x_sq = (x * x) >> 30;
        poly = TAYLOR_C9;
        poly = TAYLOR_C7 - ((x_sq * poly) >> 30);
        poly = TAYLOR_C5 - ((x_sq * poly) >> 30);
        poly = TAYLOR_C3 - ((x_sq * poly) >> 30);
        poly = TAYLOR_C1 - ((x_sq * poly) >> 30);
        prod = (x * poly) >> 30;
        rounded = (prod + (64'd1 << (29 - lrzc_pkg::TRIG_FRACTION_BITS)))
                  >> (30 - lrzc_pkg::TRIG_FRACTION_BITS);
        if (rounded > (64'd1 << lrzc_pkg::TRIG_FRACTION_BITS))
        begin
            rounded = 64'd1 << lrzc_pkg::TRIG_FRACTION_BITS;
        end
        return rounded[15:0];
    endfunction

    function automatic bit point_in_zone(input int offset,
                                         input logic [lrzc_pkg::RANGE_W-1:0] r);
        if (r == 0)
        begin
            return 1'b1;
        end
        return (64'(r) * cos_q15[offset] < (64'(front_mm) << lrzc_pkg::TRIG_FRACTION_BITS)) &&
               (64'(r) * sin_q15[offset] < (64'(half_mm) << lrzc_pkg::TRIG_FRACTION_BITS));
    endfunction

    function automatic void track_sample(input logic [lrzc_pkg::RANGE_W-1:0] r,
                                         input logic last);
        bit                hit;
        lrzc_pkg::result_t outcome;
        hit = 1'b0;
        if (turn_index < lrzc_pkg::QUARTER)
        begin
            hit = point_in_zone(turn_index, r);
        end
        else if (turn_index >= lrzc_pkg::RIGHT_START)
        begin
            hit = point_in_zone(lrzc_pkg::SAMPLES_PER_TURN - turn_index, r);
        end
        if (hit && !hit_kept)
        begin
            hit_kept   = 1'b1;
            kept_index = turn_index;
            kept_range = r;
        end
        turn_index = (turn_index + 1 >= lrzc_pkg::SAMPLES_PER_TURN) ? 0 : turn_index + 1;
        if (last)
        begin
            outcome.stop_request = hit_kept;
            outcome.hit_position = hit_kept ? kept_index[lrzc_pkg::POS_W-1:0] : '0;
            outcome.hit_distance = hit_kept ? kept_range : '0;
            pending_results.push_back(outcome);
            turn_index = 0;
            hit_kept   = 1'b0;
            kept_index = 0;
            kept_range = '0;
        end
    endfunction

    function automatic void note_mismatch(input string what, input lrzc_pkg::result_t want,
                                          input lrzc_pkg::result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t zone result %s: expected stop=%0b pos=%0d dist=%0d,",
                     $time, what, want.stop_request, want.hit_position, want.hit_distance);
            $display("    got stop=%0b pos=%0d dist=%0d",
                     got.stop_request, got.hit_position, got.hit_distance);
        end
    endfunction

    // Range draw biased toward zero, full scale and up to twice the larger zone size
    function automatic logic [lrzc_pkg::RANGE_W-1:0] pick_range();
        int reach;
        int sel;
        reach = (front_mm > half_mm) ? int'(front_mm) : int'(half_mm);
        reach = reach * 2 + 1;
        if (reach > 65535)
        begin
            reach = 65535;
        end
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            return '0;
        end
        else if (sel == 1)
        begin
            return 16'hFFFF;
        end
        else if (sel < 5)
        begin
            return 16'($urandom_range(0, reach));
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_sample(input logic [lrzc_pkg::RANGE_W-1:0] r, input logic last);
        int                gap;
        lrzc_pkg::sample_t beat;
        beat.range_mm  = r;
        beat.scan_last = last;
        if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 13);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= beat;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        track_sample(r, last);
    endtask

    // Let every pending result arrive and the front end empty out
    task automatic settle_pipeline();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_zone(input logic [lrzc_pkg::RANGE_W-1:0] front,
                            input logic [lrzc_pkg::RANGE_W-1:0] half);
        settle_pipeline();
        cfg_we    <= 1'b1;
        cfg_index <= lrzc_pkg::REG_FRONT_DISTANCE;
        cfg_data  <= front;
        @(posedge clk);
        cfg_index <= lrzc_pkg::REG_HALF_WIDTH;
        cfg_data  <= half;
        @(posedge clk);
        cfg_we   <= 1'b0;
        front_mm = front;
        half_mm  = half;
    endtask

    // Reset values: edge of the depth, out-of-zone range, kept first hit, short turns
    task automatic test_directed_defaults();
        send_sample(16'd2000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd1999, 1'b0);
        send_sample(16'd0, 1'b1);
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd40000, 1'b1);
        send_sample(16'd1500, 1'b0);
        send_sample(16'd100, 1'b1);
    endtask

    task automatic test_zone_extremes();
        set_zone(16'd2000, 16'd0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd300, 1'b0);
        send_sample(16'd0, 1'b1);
        set_zone(16'd0, 16'd800);
        send_sample(16'd1, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b1);
        set_zone(16'hFFFF, 16'hFFFF);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd65000, 1'b0);
        send_sample(16'd30000, 1'b1);
    endtask

    // One whole turn with no last mark: the left quarter stays clear so the
    // first hit lands on the right, then the index wraps and the hit survives
    task automatic test_turn_wrap();
        int          clear_range;
        int          reach;
        logic [15:0] r;
        clear_range = int'(front_mm) + int'(half_mm) + 1;
        if (clear_range > 65535)
        begin
            clear_range = 65535;
        end
        reach = (front_mm > half_mm) ? int'(front_mm) * 2 + 1 : int'(half_mm) * 2 + 1;
        if (reach > 65535)
        begin
            reach = 65535;
        end
        for (int i = 0; i < lrzc_pkg::SAMPLES_PER_TURN; i++)
        begin
            if (i < lrzc_pkg::QUARTER)
            begin
                r = 16'(clear_range);
            end
            else if (i < lrzc_pkg::RIGHT_START)
            begin
                r = 16'($urandom_range(0, 65535));
            end
            else if ($urandom_range(0, 31) == 0)
            begin
                r = 16'($urandom_range(0, reach));
            end
            else
            begin
                r = 16'(clear_range);
            end
            send_sample(r, 1'b0);
        end
        send_sample(16'd500, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd1000, 1'b1);
    endtask

    task automatic test_random_turns(input int budget);
        int sent;
        int turn_len;
        sent = 0;
        while (sent < budget)
        begin
            turn_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                   : $urandom_range(1, 40);
            for (int n = 0; n < turn_len; n++)
            begin
                send_sample(pick_range(), n == turn_len - 1);
            end
            sent += turn_len;
        end
    endtask

    // Results: compare each accepted beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                note_mismatch("with none pending", '0, result);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (result.stop_request != oldest_result.stop_request ||
                    result.hit_position != oldest_result.hit_position ||
                    result.hit_distance != oldest_result.hit_distance)
                begin
                    note_mismatch("mismatch", oldest_result, result);
                end
            end
        end
    end

    initial
    begin
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 9) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** lidar_rectangle_zone_check: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        logic [63:0] phase;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= lrzc_pkg::REG_FRONT_DISTANCE;
        cfg_data     <= '0;
        mismatch_count = 0;
        idle_enable    = 1'b1;
        front_mm   = 16'd2000;
        half_mm    = 16'd800;
        turn_index = 0;
        hit_kept   = 1'b0;
        kept_index = 0;
        kept_range = '0;
        for (int k = 0; k <= lrzc_pkg::OFFSET_MAX; k++)
        begin
            phase = (64'(k) << 32) / lrzc_pkg::SAMPLES_PER_TURN;
            if (phase > Q30_UNIT)
            begin
                phase = Q30_UNIT;
            end
            sin_q15[k] = quarter_turn_sine(phase);
            cos_q15[k] = quarter_turn_sine(Q30_UNIT - phase);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_zone_extremes();
        set_zone(16'd2000, 16'd800);
        test_turn_wrap();

        test_random_turns(60);
        set_zone(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        test_random_turns(60);
        set_zone(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)));
        test_random_turns(60);
        set_zone(16'hFFFF, 16'd0);
        test_random_turns(30);
        idle_enable = 1'b0;
        set_zone(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)));
        test_random_turns(60);

        settle_pipeline();
        if (mismatch_count == 0)
        begin
            $display("** lidar_rectangle_zone_check: PASSED **");
        end
        else
        begin
            $display("** lidar_rectangle_zone_check: FAILED **");
        end
        $finish;
    end

endmodule
